### design/lapf_pkg.sv
// ----------------------------------------------------------------------------
// lapf_pkg
// Shared widths, register indexes and types of the 3x3 Laplacian filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lapf_pkg;

    localparam int PIX_W       = 8;
    localparam int EDGE_W      = 12;
    localparam int POS_W       = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int LINE_W      = 2 * PIX_W;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // per-word side info from the scan stage to the kernel
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             produce;
        logic             last;
    } tag_t;

endpackage

`default_nettype wire

### design/lapf_ram.sv
// ----------------------------------------------------------------------------
// lapf_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lapf_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096,
    parameter int AW     = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/lapf_scan.sv
// ----------------------------------------------------------------------------
// lapf_scan
// Input stage: frame size registers, raster counters, line store read issue.
// ----------------------------------------------------------------------------
`default_nettype none

module lapf_scan #(
    parameter int MAX_WIDTH  = lapf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lapf_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(MAX_WIDTH)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lapf_pkg::PIX_W-1:0]       pixel,
    input  wire logic                             cfg_valid,
    input  wire logic [lapf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lapf_pkg::CFG_W-1:0]       cfg_data,
    output logic                                  restart,
    input  wire logic                             s1_ready,
    output logic                                  s1_valid,
    output logic      [lapf_pkg::PIX_W-1:0]       s1_pixel,
    output lapf_pkg::tag_t                        s1_tag,
    output logic      [AW-1:0]                    s1_addr,
    output logic                                  ram_re,
    output logic      [AW-1:0]                    ram_raddr
);

    import lapf_pkg::*;

    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (WW > CFG_W) ? ((WW > HW) ? WW : HW) : ((HW > CFG_W) ? HW : CFG_W);
    localparam int CXW  = (AW > POS_W) ? AW : POS_W;
    localparam int RXW  = (RW > POS_W) ? RW : POS_W;

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    tag_t             s1_tag_reg;
    logic [AW-1:0]    s1_addr_reg;

    logic [CMPW-1:0]  width_ext;
    logic [CMPW-1:0]  height_ext;
    logic [CMPW-1:0]  eff_w;
    logic [CMPW-1:0]  eff_h;
    logic             col_last;
    logic             row_last;
    logic             accept;
    logic [CXW-1:0]   col_m1;
    logic [RXW-1:0]   row_m1;
    tag_t             tag_in;

    always_comb
    begin
        width_ext  = CMPW'(width_cfg_reg);
        height_ext = CMPW'(height_cfg_reg);
        if (width_ext < CMPW'(3))
            eff_w = CMPW'(3);
        else if (width_ext > CMPW'(MAX_WIDTH))
            eff_w = CMPW'(MAX_WIDTH);
        else
            eff_w = width_ext;
        if (height_ext < CMPW'(3))
            eff_h = CMPW'(3);
        else if (height_ext > CMPW'(MAX_HEIGHT))
            eff_h = CMPW'(MAX_HEIGHT);
        else
            eff_h = height_ext;
    end

    assign col_last = (CMPW'(col_reg) == eff_w - CMPW'(1));
    assign row_last = (CMPW'(row_reg) == eff_h - CMPW'(1));
    assign s_tready = !s1_valid_reg || s1_ready;
    assign accept   = s_tvalid && s_tready;
    assign restart  = cfg_valid;

    assign col_m1 = CXW'(col_reg) - CXW'(1);
    assign row_m1 = RXW'(row_reg) - RXW'(1);

    always_comb
    begin
        tag_in.row     = row_m1[POS_W-1:0];
        tag_in.col     = col_m1[POS_W-1:0];
        tag_in.produce = (row_reg >= RW'(2)) && (col_reg >= AW'(2));
        tag_in.last    = row_last && col_last;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_valid)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= RST_IMAGE_WIDTH;
            height_cfg_reg <= RST_IMAGE_HEIGHT;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default:          ;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_tag_reg   <= tag_in;
            s1_addr_reg  <= col_reg;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_pixel  = s1_pixel_reg;
    assign s1_tag    = s1_tag_reg;
    assign s1_addr   = s1_addr_reg;
    assign ram_re    = accept;
    assign ram_raddr = col_reg;

endmodule

`default_nettype wire

### design/lapf_kernel.sv
// ----------------------------------------------------------------------------
// lapf_kernel
// 3x3 window, Laplacian adder tree, line store write-back and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lapf_kernel #(
    parameter int AW = $clog2(lapf_pkg::DEF_MAX_WIDTH)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               restart,
    input  wire logic                               s1_valid,
    output logic                                    s1_ready,
    input  wire logic [lapf_pkg::PIX_W-1:0]         s1_pixel,
    input  wire lapf_pkg::tag_t                     s1_tag,
    input  wire logic [AW-1:0]                      s1_addr,
    input  wire logic [lapf_pkg::LINE_W-1:0]        ram_rdata,
    output logic                                    ram_we,
    output logic      [AW-1:0]                      ram_waddr,
    output logic      [lapf_pkg::LINE_W-1:0]        ram_wdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [lapf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                    m_tlast
);

    import lapf_pkg::*;

    localparam int SUM_W = PIX_W + 3;

    // w<row><col>: row 0 = two rows up, col 0 = two columns left
    logic [PIX_W-1:0]  w00_reg, w01_reg, w10_reg, w11_reg, w20_reg, w21_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [EDGE_W-1:0] edge_reg;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  col_reg;
    logic              last_reg;

    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;
    logic [SUM_W-1:0]  nb_sum;
    logic [EDGE_W-1:0] edge_val;
    logic              fire;

    assign top = ram_rdata[LINE_W-1:PIX_W];
    assign mid = ram_rdata[PIX_W-1:0];

    assign s1_ready = !out_valid_reg || m_tready;
    assign fire     = s1_valid && s1_ready;

    assign nb_sum = ((SUM_W'(w00_reg) + SUM_W'(w01_reg)) + (SUM_W'(top) + SUM_W'(w10_reg)))
                  + ((SUM_W'(mid) + SUM_W'(w20_reg)) + (SUM_W'(w21_reg) + SUM_W'(s1_pixel)));
    assign edge_val = EDGE_W'(nb_sum) - EDGE_W'({w11_reg, 3'b000});

    assign ram_we    = fire;
    assign ram_waddr = s1_addr;
    assign ram_wdata = {mid, s1_pixel};

    always_comb
    begin
        if (fire)
            out_valid_next = s1_tag.produce;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            w00_reg       <= '0;
            w01_reg       <= '0;
            w10_reg       <= '0;
            w11_reg       <= '0;
            w20_reg       <= '0;
            w21_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (restart)
            begin
                w00_reg <= '0;
                w01_reg <= '0;
                w10_reg <= '0;
                w11_reg <= '0;
                w20_reg <= '0;
                w21_reg <= '0;
            end
            else if (fire)
            begin
                w00_reg <= w01_reg;
                w01_reg <= top;
                w10_reg <= w11_reg;
                w11_reg <= mid;
                w20_reg <= w21_reg;
                w21_reg <= s1_pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_tag.produce)
        begin
            edge_reg <= edge_val;
            row_reg  <= s1_tag.row;
            col_reg  <= s1_tag.col;
            last_reg <= s1_tag.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, col_reg, row_reg, edge_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### design/laplacian_3x3_filter_top.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_filter_top
// 8-neighbour 3x3 Laplacian over a raster-order grayscale pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one result word per clock for
// each interior pixel unless m_axis_tready holds it back; the word that
// completes a window passes the stage register, then the result register.
// The rate is set by the single line store RAM, which holds the two previous
// rows as one 16-bit entry per column and is read and written once per word
// through separate ports. Border pixels give no result. Line stores need no
// clearing after reset. A write to either size register restarts the frame
// at row 0, column 0; write sizes only while the stream is idle. Sizes below
// 3 act as 3, sizes above the maximum act as the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_3x3_filter_top #(
    parameter int MAX_WIDTH  = lapf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lapf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lapf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] pixel
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [11:0] edge_value, [23:12] out_row, [35:24] out_col, [39:36] zero
    output logic      [lapf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                    m_axis_tlast,   // frame_end
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lapf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lapf_pkg::CFG_W-1:0]         cfg_data
);

    import lapf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic              restart;
    logic              s1_valid;
    logic              s1_ready;
    logic [PIX_W-1:0]  s1_pixel;
    tag_t              s1_tag;
    logic [AW-1:0]     s1_addr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [LINE_W-1:0] ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [LINE_W-1:0] ram_wdata;

    assign cfg_ready = 1'b1;

    lapf_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .pixel     (s_axis_tdata[PIX_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .s1_ready  (s1_ready),
        .s1_valid  (s1_valid),
        .s1_pixel  (s1_pixel),
        .s1_tag    (s1_tag),
        .s1_addr   (s1_addr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    lapf_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH),
        .AW     (AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lapf_kernel #(
        .AW (AW)
    ) u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_pixel  (s1_pixel),
        .s1_tag    (s1_tag),
        .s1_addr   (s1_addr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid))
        else $error("result appeared without a word in the stage register");

    a_ram_write_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s1_valid && s1_ready)
        else $error("line store written without a word advancing");
`endif

endmodule

`default_nettype wire
